@@ rtl/prc_pkg.sv @@
package prc_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int CONTEXT_COUNT_DEF = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam int SAMPLE_W = 9;
	localparam int SYMBOL_W = 10;
	localparam int CTX_W = 3;
	localparam int PWIDTH_W = 13;
	localparam int PHEIGHT_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOUR_MODE = 2'd2;

	localparam logic signed [11:0] OFFSET_GREY = 12'sd255;
	localparam logic signed [11:0] OFFSET_COLOUR = 12'sd510;
	localparam logic signed [11:0] SYMBOL_MAX = 12'sd1020;
	localparam int BOUND_COUNT = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// neighbours already forced to zero outside the image
	typedef struct packed {
		sample_t s;
		sample_t a;
		sample_t b;
		sample_t c;
		logic    last;
	} prc_item_t;

	function automatic logic [10:0] activity_bound(input int k);
		logic [10:0] r;
		case (k)
			0: r = 11'd4;
			1: r = 11'd12;
			2: r = 11'd28;
			3: r = 11'd60;
			4: r = 11'd124;
			5: r = 11'd252;
			default: r = 11'd1024;
		endcase
		return r;
	endfunction

	function automatic logic [11:0] mag12(input logic signed [11:0] v);
		return v[11] ? 12'(-v) : 12'(v);
	endfunction

endpackage

@@ rtl/prc_front.sv @@
module prc_front
	import prc_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sample_t               in_sample,
	input  logic [PWIDTH_W-1:0]   plane_width,
	input  logic [PHEIGHT_W-1:0]  plane_height,
	output logic                  push,
	output prc_item_t             push_item,
	input  logic                  queue_full
);

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [XW-1:0]        x_q;
	logic [PHEIGHT_W-1:0] y_q;
	sample_t              left_q;
	sample_t              rd_q;
	sample_t              mem [MAX_WIDTH];

	logic                 v_s1;
	sample_t              s_s1;
	sample_t              a_s1;
	sample_t              c_s1;
	logic                 up_s1;
	logic                 last_s1;

	logic                 accept;
	logic                 has_left;
	logic                 has_up;
	logic                 last_col;
	logic                 last_row;
	logic [31:0]          w_lim;
	logic [31:0]          h_lim;

	assign in_ready = !v_s1 || !queue_full;
	assign accept = in_valid && in_ready;
	assign push = v_s1 && !queue_full;

	assign has_left = x_q != '0;
	assign has_up = y_q != '0;

	always_comb begin
		w_lim = 32'(plane_width);
		if (w_lim == 32'd0)
			w_lim = 32'd1;
		if (w_lim > 32'(MAX_WIDTH))
			w_lim = 32'(MAX_WIDTH);
		h_lim = (plane_height == '0) ? 32'd1 : 32'(plane_height);
	end

	assign last_col = (32'(x_q) + 32'd1) >= w_lim;
	assign last_row = (32'(y_q) + 32'd1) >= h_lim;

	always_comb begin
		push_item.s = s_s1;
		push_item.a = a_s1;
		push_item.b = up_s1 ? rd_q : '0;
		push_item.c = c_s1;
		push_item.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			left_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				left_q <= in_sample;
				if (last_col) begin
					x_q <= '0;
					y_q <= last_row ? '0 : y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// line buffer: read returns the previous row before this sample overwrites it
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[x_q];
			mem[x_q] <= in_sample;
			c_s1 <= (has_left && has_up) ? rd_q : '0;
			s_s1 <= in_sample;
			a_s1 <= has_left ? left_q : '0;
			up_s1 <= has_up;
			last_s1 <= last_col && last_row;
		end
	end

endmodule

@@ rtl/prc_queue.sv @@
module prc_queue
	import prc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  prc_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output prc_item_t head_item
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	prc_item_t      slots [QUEUE_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    count_q;

	assign full = count_q == (AW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item = slots[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_q] <= push_item;
	end

endmodule

@@ rtl/prc_back.sv @@
module prc_back
	import prc_pkg::*;
#(
	parameter int CONTEXT_COUNT = CONTEXT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  prc_item_t           head_item,
	output logic                pop,
	input  logic                colour_mode,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SYMBOL_W-1:0] out_symbol,
	output logic [CTX_W-1:0]    out_context,
	output logic                out_last
);

	logic                out_v_q;
	logic [SYMBOL_W-1:0] sym_q;
	logic [CTX_W-1:0]    ctx_q;
	logic                last_q;

	logic signed [11:0]  a_x;
	logic signed [11:0]  b_x;
	logic signed [11:0]  c_x;
	logic [11:0]         da;
	logic [11:0]         db;
	logic [11:0]         dc;
	sample_t             pred;
	logic signed [11:0]  sym_raw;
	logic [SYMBOL_W-1:0] sym_d;
	logic [10:0]         act;
	logic [CTX_W-1:0]    ctx_d;

	assign pop = head_valid && (!out_v_q || out_ready);

	always_comb begin
		a_x = 12'(head_item.a);
		b_x = 12'(head_item.b);
		c_x = 12'(head_item.c);
		da = mag12(b_x - c_x);
		db = mag12(a_x - c_x);
		dc = mag12(a_x + b_x - c_x - c_x);
		if (da <= db && da <= dc)
			pred = head_item.a;
		else if (db <= dc)
			pred = head_item.b;
		else
			pred = head_item.c;

		sym_raw = 12'(head_item.s) - 12'(pred) + (colour_mode ? OFFSET_COLOUR : OFFSET_GREY);
		if (sym_raw < 12'sd0)
			sym_d = '0;
		else if (sym_raw > SYMBOL_MAX)
			sym_d = SYMBOL_W'(SYMBOL_MAX);
		else
			sym_d = SYMBOL_W'(sym_raw);

		act = 11'(db) + 11'(da);
		ctx_d = CTX_W'(CONTEXT_COUNT - 1);
		// descending so the lowest matching class wins
		for (int k = CONTEXT_COUNT - 2; k >= 0; k--) begin
			if (k < BOUND_COUNT && act < activity_bound(k))
				ctx_d = CTX_W'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sym_q <= sym_d;
			ctx_q <= ctx_d;
			last_q <= head_item.last;
		end
	end

	assign out_valid = out_v_q;
	assign out_symbol = sym_q;
	assign out_context = ctx_q;
	assign out_last = last_q;

endmodule

@@ rtl/paeth_residual_context_stage.sv @@
// Paeth residual and activity-context stage, one plane sample per request.
// An accepted sample passes the front stage registers, a queue slot and the output registers to result valid.
// Throughput: one sample per cycle unless m_axis_tready stalls; the line buffer has one read and one write per cycle.
// A 4-entry queue sits between the position/line-buffer front and the predictor back.
// Reset clears position, the left neighbour, queue and registers (width 1, height 1, grey);
// the line buffer is not cleared, and its read data is used only for rows after the first.
module paeth_residual_context_stage
	import prc_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int CONTEXT_COUNT = CONTEXT_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [15:0]            s_axis_tdata,   // [8:0] sample
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata,   // [9:0] symbol, [12:10] context_res
	output logic                   m_axis_tlast,   // end_of_plane
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [PWIDTH_W-1:0]  plane_width_q;
	logic [PHEIGHT_W-1:0] plane_height_q;
	logic                 colour_mode_q;

	logic                 push;
	prc_item_t            push_item;
	logic                 queue_full;
	logic                 pop;
	logic                 head_valid;
	prc_item_t            head_item;
	logic [SYMBOL_W-1:0]  symbol;
	logic [CTX_W-1:0]     context_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_width_q <= PWIDTH_W'(1);
			plane_height_q <= PHEIGHT_W'(1);
			colour_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PLANE_WIDTH: plane_width_q <= cfg_data[PWIDTH_W-1:0];
				REG_PLANE_HEIGHT: plane_height_q <= cfg_data[PHEIGHT_W-1:0];
				REG_COLOUR_MODE: colour_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	prc_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_sample(s_axis_tdata[SAMPLE_W-1:0]),
		.plane_width(plane_width_q),
		.plane_height(plane_height_q),
		.push(push),
		.push_item(push_item),
		.queue_full(queue_full)
	);

	prc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(queue_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_item(head_item)
	);

	prc_back #(
		.CONTEXT_COUNT(CONTEXT_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_item(head_item),
		.pop(pop),
		.colour_mode(colour_mode_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_symbol(symbol),
		.out_context(context_res),
		.out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, context_res, symbol};

endmodule
